// File: src/qau_pkg.sv
// Shared types, codes and helpers for the quaternion arithmetic unit.
// No dependencies.
package qau_pkg;

   localparam int FRAC_BITS_DEF = 12;
   localparam int DIV_QW = 17;

   typedef enum logic [2:0] {
      ACT_ADD   = 3'd0,
      ACT_SUB   = 3'd1,
      ACT_MUL   = 3'd2,
      ACT_SCALE = 3'd3,
      ACT_DIV   = 3'd4,
      ACT_NSQ   = 3'd5,
      ACT_NORM  = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_DIVZ = 2'd2
   } status_type;

   localparam logic [15:0] Q_MAX = 16'h7FFF;
   localparam logic [15:0] Q_MIN = 16'h8000;

   typedef struct packed {
      logic signed [15:0] w;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } quat_type;

   // {saturated, value} of a 17-bit sum clipped to 16 bits
   function automatic logic [16:0] sat17(input logic signed [16:0] v);
      if (v > 17'sd32767) begin
         return {1'b1, Q_MAX};
      end else if (v < -17'sd32768) begin
         return {1'b1, Q_MIN};
      end
      return {1'b0, v[15:0]};
   endfunction

endpackage

// File: src/qau_sqrt.sv
// Pipelined restoring square root, one root bit per stage.
// Depends on nothing but the stage enable from the top level.
module qau_sqrt #(
   parameter int RW = 28
) (
   input  logic              clock,
   input  logic              adv,
   input  logic [2*RW-1:0]   radicand,
   output logic [RW-1:0]     root_out,
   output logic [RW+1:0]     rem_out
);

   logic [2*RW-1:0] rad_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [RW+1:0]   rem_ff  [RW];
   logic [2*RW-1:0] rad_in_a  [RW];
   logic [RW-1:0]   root_in_a [RW];
   logic [RW+1:0]   rem_in_a  [RW];
   logic [2*RW-1:0] rad_in  [RW];
   logic [RW-1:0]   root_in [RW];
   logic [RW+1:0]   rem_in  [RW];

   always_comb begin
      logic [RW+3:0] r2;
      logic [RW+3:0] trial;
      rad_in_a[0]  = radicand;
      root_in_a[0] = '0;
      rem_in_a[0]  = '0;
      for (int k = 1; k < RW; k++) begin
         rad_in_a[k]  = rad_ff[k-1];
         root_in_a[k] = root_ff[k-1];
         rem_in_a[k]  = rem_ff[k-1];
      end
      for (int k = 0; k < RW; k++) begin
         r2    = {rem_in_a[k], rad_in_a[k][2*RW-1 -: 2]};
         trial = (RW+4)'({root_in_a[k], 2'b01});
         if (r2 >= trial) begin
            rem_in[k]  = (RW+2)'(r2 - trial);
            root_in[k] = {root_in_a[k][RW-2:0], 1'b1};
         end else begin
            rem_in[k]  = (RW+2)'(r2);
            root_in[k] = {root_in_a[k][RW-2:0], 1'b0};
         end
         rad_in[k] = rad_in_a[k] << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < RW; k++) begin
            rad_ff[k]  <= rad_in[k];
            root_ff[k] <= root_in[k];
            rem_ff[k]  <= rem_in[k];
         end
      end
   end

   assign root_out = root_ff[RW-1];
   assign rem_out  = rem_ff[RW-1];

endmodule

// File: src/quaternion_arithmetic_unit.sv
// Top level of the quaternion arithmetic unit: operand stages, multiply and
// sum stages, bit-serial divider lanes, output register.
// Depends on qau_pkg and qau_sqrt.
//
// Usage: an item on req_* (action, quaternions b and c, scalar) is taken when
// req_valid is high and req_stall low. Each item gives exactly one result on
// rsp_*, in order, held while rsp_stall is high.
// Path from acceptance to rsp_valid: four operand/multiply/sum/round stages,
// FRAC_BITS + 16 stages of the square root (one root bit per stage, the
// divider lanes finish inside the same span at one quotient bit per stage),
// then the output register.
// Throughput: one item per cycle. The whole pipeline advances together;
// when a result sits in the output register and rsp_stall is high, every
// stage holds and req_stall is raised in the same cycle.
// Reset clears all valid bits; the pipeline is empty and ready afterwards.
module quaternion_arithmetic_unit #(
   parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_action,
   input  logic signed [15:0] req_b_w,
   input  logic signed [15:0] req_b_x,
   input  logic signed [15:0] req_b_y,
   input  logic signed [15:0] req_b_z,
   input  logic signed [15:0] req_c_w,
   input  logic signed [15:0] req_c_x,
   input  logic signed [15:0] req_c_y,
   input  logic signed [15:0] req_c_z,
   input  logic signed [15:0] req_scalar_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_result_w,
   output logic signed [15:0] rsp_result_x,
   output logic signed [15:0] rsp_result_y,
   output logic signed [15:0] rsp_result_z,
   output logic [31:0]        rsp_scalar_out,
   output logic [1:0]         rsp_status
);

   localparam int QW    = qau_pkg::DIV_QW;
   localparam int NUM_W = 17 + FRAC_BITS;
   localparam int RW    = FRAC_BITS + 16;
   localparam int ITER  = RW;
   localparam logic [33:0] HALF = 34'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      qau_pkg::quat_type    res;
      logic [1:0]           stat;
      logic [31:0]          scal;
      logic                 use_div;
      logic                 use_norm;
      logic [15:0]          ad;
      logic [3:0]           ovf;
      logic [3:0]           neg;
      logic [3:0][QW-1:0]   quo;
      logic [3:0][QW-1:0]   rem;
      logic [3:0][QW-1:0]   low;
   } pipe_type;

   function automatic logic [16:0] rnd_sat(input logic signed [33:0] v);
      logic [33:0] mag;
      logic [33:0] m;
      mag = v[33] ? 34'(-v) : 34'(v);
      m   = (mag + HALF) >> FRAC_BITS;
      if (!v[33]) begin
         if (m > 34'd32767) return {1'b1, qau_pkg::Q_MAX};
         return {1'b0, m[15:0]};
      end
      if (m > 34'd32768) return {1'b1, qau_pkg::Q_MIN};
      return {1'b0, 16'(-m[15:0])};
   endfunction

   function automatic pipe_type div_step(input pipe_type p);
      logic [QW-1:0] r2;
      logic          qb;
      for (int i = 0; i < 4; i++) begin
         r2 = {p.rem[i][QW-2:0], p.low[i][QW-1]};
         qb = 1'b0;
         if (r2 >= QW'(p.ad)) begin
            r2 = r2 - QW'(p.ad);
            qb = 1'b1;
         end
         p.rem[i] = r2;
         p.quo[i] = {p.quo[i][QW-2:0], qb};
         p.low[i] = p.low[i] << 1;
      end
      return p;
   endfunction

   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // stage 0: operands
   logic               s0_valid_ff;
   logic [2:0]         s0_act_ff;
   logic signed [15:0] s0_b_ff [4];
   logic signed [15:0] s0_c_ff [4];
   logic signed [15:0] s0_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_act_ff  <= req_action;
         s0_b_ff[0] <= req_b_w;
         s0_b_ff[1] <= req_b_x;
         s0_b_ff[2] <= req_b_y;
         s0_b_ff[3] <= req_b_z;
         s0_c_ff[0] <= req_c_w;
         s0_c_ff[1] <= req_c_x;
         s0_c_ff[2] <= req_c_y;
         s0_c_ff[3] <= req_c_z;
         s0_s_ff    <= req_scalar_in;
      end
   end

   // stage 1: products, add/sub, divider set-up
   logic               s1_valid_ff;
   logic [2:0]         s1_act_ff;
   logic signed [31:0] s1_p_ff  [4][4];
   logic signed [31:0] s1_sp_ff [4];
   logic [30:0]        s1_sq_ff [4];
   logic [15:0]        s1_as_ff [4];
   logic [3:0]         s1_as_sat_ff;
   logic [15:0]        s1_ad_ff;
   logic [3:0]         s1_ovf_ff;
   logic [3:0]         s1_neg_ff;
   logic [QW-1:0]      s1_rem_ff [4];
   logic [QW-1:0]      s1_low_ff [4];
   logic               s1_divz_ff;
   logic [15:0]        s1_dz_ff [4];

   logic signed [31:0] s1_p_in  [4][4];
   logic signed [31:0] s1_sp_in [4];
   logic [30:0]        s1_sq_in [4];
   logic [15:0]        s1_as_in [4];
   logic [3:0]         s1_as_sat_in;
   logic [15:0]        s1_ad_in;
   logic [3:0]         s1_ovf_in;
   logic [3:0]         s1_neg_in;
   logic [QW-1:0]      s1_rem_in [4];
   logic [QW-1:0]      s1_low_in [4];
   logic [15:0]        s1_dz_in [4];

   always_comb begin
      logic signed [16:0] sv;
      logic [16:0]        st;
      logic [15:0]        mb;
      logic [NUM_W-1:0]   num;
      logic signed [31:0] sq;
      s1_ad_in = s0_s_ff[15] ? 16'(-s0_s_ff) : 16'(s0_s_ff);
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            s1_p_in[i][j] = s0_b_ff[i] * s0_c_ff[j];
         end
         s1_sp_in[i] = s0_s_ff * s0_b_ff[i];
         sq          = s0_b_ff[i] * s0_b_ff[i];
         s1_sq_in[i] = sq[30:0];
         if (s0_act_ff == qau_pkg::ACT_SUB) begin
            sv = 17'(s0_b_ff[i]) - 17'(s0_c_ff[i]);
         end else begin
            sv = 17'(s0_b_ff[i]) + 17'(s0_c_ff[i]);
         end
         st              = qau_pkg::sat17(sv);
         s1_as_in[i]     = st[15:0];
         s1_as_sat_in[i] = st[16];
         mb            = s0_b_ff[i][15] ? 16'(-s0_b_ff[i]) : 16'(s0_b_ff[i]);
         num           = NUM_W'({mb, {FRAC_BITS{1'b0}}}) + NUM_W'(s1_ad_in >> 1);
         s1_ovf_in[i]  = (num >> QW) >= NUM_W'(s1_ad_in);
         s1_neg_in[i]  = s0_b_ff[i][15] ^ s0_s_ff[15];
         s1_rem_in[i]  = QW'(num >> QW);
         s1_low_in[i]  = num[QW-1:0];
         if (s0_b_ff[i] > 16'sd0) begin
            s1_dz_in[i] = qau_pkg::Q_MAX;
         end else if (s0_b_ff[i] < 16'sd0) begin
            s1_dz_in[i] = qau_pkg::Q_MIN;
         end else begin
            s1_dz_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_act_ff    <= s0_act_ff;
         s1_p_ff      <= s1_p_in;
         s1_sp_ff     <= s1_sp_in;
         s1_sq_ff     <= s1_sq_in;
         s1_as_ff     <= s1_as_in;
         s1_as_sat_ff <= s1_as_sat_in;
         s1_ad_ff     <= s1_ad_in;
         s1_ovf_ff    <= s1_ovf_in;
         s1_neg_ff    <= s1_neg_in;
         s1_rem_ff    <= s1_rem_in;
         s1_low_ff    <= s1_low_in;
         s1_divz_ff   <= (s0_s_ff == 16'sd0);
         s1_dz_ff     <= s1_dz_in;
      end
   end

   // stage 2: Hamilton sums, sum of squares
   logic               s2_valid_ff;
   logic [2:0]         s2_act_ff;
   logic signed [33:0] s2_h_ff  [4];
   logic [32:0]        s2_sum_ff;
   logic signed [31:0] s2_sp_ff [4];
   logic [15:0]        s2_as_ff [4];
   logic [3:0]         s2_as_sat_ff;
   logic [15:0]        s2_ad_ff;
   logic [3:0]         s2_ovf_ff;
   logic [3:0]         s2_neg_ff;
   logic [QW-1:0]      s2_rem_ff [4];
   logic [QW-1:0]      s2_low_ff [4];
   logic               s2_divz_ff;
   logic [15:0]        s2_dz_ff [4];

   logic signed [33:0] s2_h_in [4];

   always_comb begin
      s2_h_in[0] = 34'(s1_p_ff[0][0]) - 34'(s1_p_ff[1][1])
                 - 34'(s1_p_ff[2][2]) - 34'(s1_p_ff[3][3]);
      s2_h_in[1] = 34'(s1_p_ff[0][1]) + 34'(s1_p_ff[1][0])
                 - 34'(s1_p_ff[2][3]) + 34'(s1_p_ff[3][2]);
      s2_h_in[2] = 34'(s1_p_ff[0][2]) + 34'(s1_p_ff[1][3])
                 + 34'(s1_p_ff[2][0]) - 34'(s1_p_ff[3][1]);
      s2_h_in[3] = 34'(s1_p_ff[0][3]) - 34'(s1_p_ff[1][2])
                 + 34'(s1_p_ff[2][1]) + 34'(s1_p_ff[3][0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_act_ff    <= s1_act_ff;
         s2_h_ff      <= s2_h_in;
         s2_sum_ff    <= 33'(s1_sq_ff[0]) + 33'(s1_sq_ff[1])
                       + 33'(s1_sq_ff[2]) + 33'(s1_sq_ff[3]);
         s2_sp_ff     <= s1_sp_ff;
         s2_as_ff     <= s1_as_ff;
         s2_as_sat_ff <= s1_as_sat_ff;
         s2_ad_ff     <= s1_ad_ff;
         s2_ovf_ff    <= s1_ovf_ff;
         s2_neg_ff    <= s1_neg_ff;
         s2_rem_ff    <= s1_rem_ff;
         s2_low_ff    <= s1_low_ff;
         s2_divz_ff   <= s1_divz_ff;
         s2_dz_ff     <= s1_dz_ff;
      end
   end

   // stage 3 (pipe_ff[0]) and divider stages
   logic            vld_ff  [ITER+1];
   pipe_type        pipe_ff [ITER+1];
   pipe_type        pipe_in [ITER+1];
   logic [2*RW-1:0] rad_ff;

   always_comb begin
      pipe_type    p;
      logic [16:0] rs [4];
      logic        sat;
      logic [15:0] rv [4];
      p          = '0;
      p.ad       = s2_ad_ff;
      p.ovf      = s2_ovf_ff;
      p.neg      = s2_neg_ff;
      sat        = 1'b0;
      for (int i = 0; i < 4; i++) begin
         p.rem[i] = s2_rem_ff[i];
         p.low[i] = s2_low_ff[i];
         rv[i]    = '0;
         if (s2_act_ff == qau_pkg::ACT_MUL) begin
            rs[i] = rnd_sat(s2_h_ff[i]);
         end else begin
            rs[i] = rnd_sat(34'(s2_sp_ff[i]));
         end
      end
      case (s2_act_ff)
         qau_pkg::ACT_ADD, qau_pkg::ACT_SUB: begin
            for (int i = 0; i < 4; i++) rv[i] = s2_as_ff[i];
            sat = |s2_as_sat_ff;
         end
         qau_pkg::ACT_MUL, qau_pkg::ACT_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               rv[i] = rs[i][15:0];
               sat   = sat | rs[i][16];
            end
         end
         qau_pkg::ACT_DIV: begin
            if (s2_divz_ff) begin
               for (int i = 0; i < 4; i++) rv[i] = s2_dz_ff[i];
               p.stat = qau_pkg::ST_DIVZ;
            end else begin
               p.use_div = 1'b1;
            end
         end
         qau_pkg::ACT_NSQ: begin
            p.scal = 32'((s2_sum_ff + 33'd1) >> 1);
         end
         qau_pkg::ACT_NORM: begin
            p.use_norm = 1'b1;
         end
         default: begin
         end
      endcase
      if (sat) p.stat = qau_pkg::ST_SAT;
      p.res.w    = rv[0];
      p.res.x    = rv[1];
      p.res.y    = rv[2];
      p.res.z    = rv[3];
      pipe_in[0] = p;
      for (int k = 0; k < ITER; k++) begin
         if (k < QW) begin
            pipe_in[k+1] = div_step(pipe_ff[k]);
         end else begin
            pipe_in[k+1] = pipe_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= ITER; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= s2_valid_ff;
         for (int k = 1; k <= ITER; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff <= (2*RW)'(s2_sum_ff) << (2*FRAC_BITS - 2);
         for (int k = 0; k <= ITER; k++) pipe_ff[k] <= pipe_in[k];
      end
   end

   logic [RW-1:0] root;
   logic [RW+1:0] root_rem;

   qau_sqrt #(
      .RW (RW)
   ) u_sqrt (
      .clock    (clock),
      .adv      (adv),
      .radicand (rad_ff),
      .root_out (root),
      .rem_out  (root_rem)
   );

   // output stage
   logic               rsp_valid_ff;
   qau_pkg::quat_type  rsp_res_ff;
   logic [31:0]        rsp_scal_ff;
   logic [1:0]         rsp_stat_ff;
   qau_pkg::quat_type  rsp_res_in;
   logic [31:0]        rsp_scal_in;
   logic [1:0]         rsp_stat_in;

   always_comb begin
      pipe_type    p;
      logic [15:0] dv [4];
      logic        dsat;
      logic [QW-1:0] q;
      logic [RW:0] rr;
      p    = pipe_ff[ITER];
      dsat = 1'b0;
      for (int i = 0; i < 4; i++) begin
         q = p.quo[i];
         if (p.neg[i]) begin
            if (p.ovf[i] || q > QW'(32768)) begin
               dv[i] = qau_pkg::Q_MIN;
               dsat  = 1'b1;
            end else begin
               dv[i] = 16'(-q[15:0]);
            end
         end else begin
            if (p.ovf[i] || q > QW'(32767)) begin
               dv[i] = qau_pkg::Q_MAX;
               dsat  = 1'b1;
            end else begin
               dv[i] = q[15:0];
            end
         end
      end
      rr          = (RW+1)'(root) + (RW+1)'(root_rem > (RW+2)'(root));
      rsp_res_in  = p.res;
      rsp_scal_in = p.scal;
      rsp_stat_in = p.stat;
      if (p.use_div) begin
         rsp_res_in.w = dv[0];
         rsp_res_in.x = dv[1];
         rsp_res_in.y = dv[2];
         rsp_res_in.z = dv[3];
         rsp_stat_in  = dsat ? qau_pkg::ST_SAT : qau_pkg::ST_OK;
      end
      if (p.use_norm) begin
         rsp_scal_in = 32'(rr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[ITER];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_res_ff  <= rsp_res_in;
         rsp_scal_ff <= rsp_scal_in;
         rsp_stat_ff <= rsp_stat_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result_w   = rsp_res_ff.w;
   assign rsp_result_x   = rsp_res_ff.x;
   assign rsp_result_y   = rsp_res_ff.y;
   assign rsp_result_z   = rsp_res_ff.z;
   assign rsp_scalar_out = rsp_scal_ff;
   assign rsp_status     = rsp_stat_ff;

endmodule

// File: src/qau_checker.sv
// Port-level checks for the quaternion arithmetic unit, bound to the top.
// Depends on qau_pkg and quaternion_arithmetic_unit.
module qau_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_result_w,
   input logic [31:0]        rsp_scalar_out,
   input logic [1:0]         rsp_status
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_scalar_out))
      else $error("result dropped or changed under stall");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while output blocked");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_divz_scalar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == qau_pkg::ST_DIVZ |-> rsp_scalar_out == 32'd0)
      else $error("norm output on divide by zero");

   a_norm_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scalar_out != 32'd0
         |-> rsp_status == qau_pkg::ST_OK && rsp_result_w == 16'sd0)
      else $error("norm item with quaternion output");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_result_w   (rsp_result_w),
   .rsp_scalar_out (rsp_scalar_out),
   .rsp_status     (rsp_status)
);
